>>> hdl/amo_pkg.sv
package amo_pkg;

  // Fixed field widths
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 11;
  localparam int OPC_W   = 4;
  localparam int SIZE_W  = 2;
  localparam int WIDX_W  = ADDR_W - 3;  // word index bits carried by a byte address

  // Request opcodes
  localparam logic [OPC_W-1:0] OP_XCHG     = 4'd0;
  localparam logic [OPC_W-1:0] OP_RELEASE  = 4'd1;
  localparam logic [OPC_W-1:0] OP_CAS      = 4'd2;
  localparam logic [OPC_W-1:0] OP_F_ADD    = 4'd3;
  localparam logic [OPC_W-1:0] OP_F_SUB    = 4'd4;
  localparam logic [OPC_W-1:0] OP_F_AND    = 4'd5;
  localparam logic [OPC_W-1:0] OP_F_OR     = 4'd6;
  localparam logic [OPC_W-1:0] OP_F_XOR    = 4'd7;
  localparam logic [OPC_W-1:0] OP_F_NAND   = 4'd8;
  localparam logic [OPC_W-1:0] OP_T_ADD    = 4'd9;
  localparam logic [OPC_W-1:0] OP_T_SUB    = 4'd10;
  localparam logic [OPC_W-1:0] OP_T_AND    = 4'd11;
  localparam logic [OPC_W-1:0] OP_T_OR     = 4'd12;
  localparam logic [OPC_W-1:0] OP_T_XOR    = 4'd13;
  localparam logic [OPC_W-1:0] OP_T_NAND   = 4'd14;
  localparam logic [OPC_W-1:0] OP_NONE     = 4'd15;

  // Access size codes
  localparam logic [SIZE_W-1:0] SZ_1 = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_2 = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_4 = 2'd2;
  localparam logic [SIZE_W-1:0] SZ_8 = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NAND
  } alu_op_t;

  // Operation and operands handed to the shared unit
  typedef struct packed {
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              carry;  // carry out; for subtract: no borrow
  } alu_rsp_t;

  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SZ_1:    m = 64'h0000_0000_0000_00FF;
      SZ_2:    m = 64'h0000_0000_0000_FFFF;
      SZ_4:    m = 64'h0000_0000_FFFF_FFFF;
      SZ_8:    m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic misaligned(input logic [2:0] low, input logic [SIZE_W-1:0] sz);
    logic bad;
    case (sz)
      SZ_1:    bad = 1'b0;
      SZ_2:    bad = low[0];
      SZ_4:    bad = |low[1:0];
      SZ_8:    bad = |low;
      default: bad = 1'b0;
    endcase
    return bad;
  endfunction

  // Read-modify-write opcode to shared-unit operation
  function automatic alu_op_t op_to_alu(input logic [OPC_W-1:0] opc);
    alu_op_t op;
    case (opc) inside
      OP_F_ADD, OP_T_ADD:   op = ALU_ADD;
      OP_F_SUB, OP_T_SUB:   op = ALU_SUB;
      OP_F_AND, OP_T_AND:   op = ALU_AND;
      OP_F_OR,  OP_T_OR:    op = ALU_OR;
      OP_F_XOR, OP_T_XOR:   op = ALU_XOR;
      OP_F_NAND, OP_T_NAND: op = ALU_NAND;
      default:              op = ALU_XOR;
    endcase
    return op;
  endfunction

endpackage

>>> hdl/atomic_memory_op_unit.sv
// Atomic read-modify-write unit over a local store of MEM_WORDS 64-bit words.
// Input channel (in_*): one request transaction per valid/ready handshake,
// carrying opcode, byte address, size code, operand and compare value.
// Result channel (out_*): exactly one result transaction per request, in order.
// After reset the store is cleared one word per cycle; in_ready stays low
// until it is done.
// A normal request first reduces the word index modulo MEM_WORDS (quotient
// by reciprocal multiply, then the remainder on the shared adder), then
// does memory read, execute on the shared unit, write-back and result load.
// Misaligned requests and the unused opcode skip the memory and go straight
// to result load.
// in_ready is high only in the idle state, so one request is in flight at a
// time; the next one is taken the cycle after the result is loaded. The
// result sits in an output register: a stalled receiver holds it there,
// while the unit accepts and works the next request up to the point of
// loading its result.
module atomic_memory_op_unit #(
  parameter int MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [10:0] in_byte_address,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_operand_value,
  input  logic [63:0] in_compare_value,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_value,
  output logic        out_swap_done,
  output logic        out_align_error
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);
  // word index is 8 bits, so a store of 256 words or more never wraps
  localparam int          WRAP_M   = (MEM_WORDS < 256) ? MEM_WORDS : 256;
  localparam logic [16:0] WRAP_RCP = 17'((65536 + WRAP_M - 1) / WRAP_M);
  localparam logic [8:0]  WRAP_MV  = 9'(WRAP_M);

  // Word store
  logic [63:0] mem [MEM_WORDS];

  amo_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r;
  logic [2:0]    step_r;
  logic [7:0]    rem_r;
  logic [7:0]    quo_r;

  logic [3:0]    opc_r;
  logic [10:0]   addr_r;
  logic [1:0]    size_r;
  logic [63:0]   opv_r;
  logic [63:0]   cmpv_r;

  logic [63:0]   rd_data_r;
  logic [63:0]   new_word_r;
  logic          wr_en_r;
  logic [63:0]   res_r;
  logic          done_r;
  logic          err_r;

  logic          out_valid_r;
  logic [63:0]   out_res_r;
  logic          out_done_r;
  logic          out_err_r;

  amo_pkg::alu_req_t alu_req;
  amo_pkg::alu_rsp_t alu_rsp;

  logic          in_acc;
  logic          in_skip;
  logic          out_load;
  logic [amo_pkg::WIDX_W-1:0] widx;
  logic [23:0]   quo_prod;
  logic [16:0]   quo_back;
  logic [5:0]    sh;
  logic [63:0]   mask;
  logic [63:0]   old_val;
  logic [63:0]   nv;
  logic          cas_hit;
  logic [AW-1:0] idx;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [63:0]   mem_wd;

  amo_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_acc   = in_valid && in_ready;
  assign in_skip  = (in_opcode == amo_pkg::OP_NONE) ||
                    amo_pkg::misaligned(in_byte_address[2:0], in_size_code);
  assign out_load = (state_r == amo_pkg::ST_RESP) && (!out_valid_r || out_ready);

  // Datapath helpers
  assign widx     = addr_r[10:3];
  assign quo_prod = {16'd0, widx} * {7'd0, WRAP_RCP};
  assign quo_back = {9'd0, quo_r} * {8'd0, WRAP_MV};
  assign idx      = AW'(rem_r);
  assign sh       = {addr_r[2:0], 3'b000};
  assign mask     = amo_pkg::size_mask(size_r);
  assign old_val  = (rd_data_r >> sh) & mask;
  assign cas_hit  = (alu_rsp.res == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amo_pkg::ST_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = amo_pkg::ST_IDLE;
      amo_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = in_skip ? amo_pkg::ST_RESP : amo_pkg::ST_MOD;
      end
      amo_pkg::ST_MOD:   if (step_r == 3'd0) state_nxt = amo_pkg::ST_READ;
      amo_pkg::ST_READ:  state_nxt = amo_pkg::ST_EXEC;
      amo_pkg::ST_EXEC:  state_nxt = amo_pkg::ST_WRITE;
      amo_pkg::ST_WRITE: state_nxt = amo_pkg::ST_RESP;
      amo_pkg::ST_RESP:  if (out_load) state_nxt = amo_pkg::ST_IDLE;
      default:           state_nxt = amo_pkg::ST_CLEAR;
    endcase
  end

  // FSM outputs: handshake, shared unit control, memory port
  always_comb begin
    in_ready = 1'b0;
    alu_req  = '{op: amo_pkg::ALU_SUB, a: 64'(widx), b: 64'(quo_back)};
    mem_we   = 1'b0;
    mem_wa   = idx;
    mem_wd   = new_word_r;
    case (state_r)
      amo_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
      end
      amo_pkg::ST_IDLE: in_ready = 1'b1;
      amo_pkg::ST_EXEC: begin
        if (opc_r == amo_pkg::OP_CAS) begin
          alu_req = '{op: amo_pkg::ALU_XOR, a: old_val, b: cmpv_r};
        end else begin
          alu_req = '{op: amo_pkg::op_to_alu(opc_r), a: old_val, b: opv_r};
        end
      end
      amo_pkg::ST_WRITE: mem_we = wr_en_r;
      default: ;
    endcase
  end

  // New lane value
  always_comb begin
    case (opc_r)
      amo_pkg::OP_XCHG:    nv = opv_r;
      amo_pkg::OP_RELEASE: nv = '0;
      amo_pkg::OP_CAS:     nv = opv_r;
      default:             nv = alu_rsp.res & mask;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amo_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == amo_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, index reduction and execute
  always_ff @(posedge clk) begin
    if (in_acc) begin
      opc_r  <= in_opcode;
      addr_r <= in_byte_address;
      size_r <= in_size_code;
      opv_r  <= in_operand_value & amo_pkg::size_mask(in_size_code);
      cmpv_r <= in_compare_value & amo_pkg::size_mask(in_size_code);
      rem_r  <= '0;
      step_r <= 3'd1;
      res_r  <= '0;
      done_r <= 1'b0;
      err_r  <= (in_opcode != amo_pkg::OP_NONE) &&
                amo_pkg::misaligned(in_byte_address[2:0], in_size_code);
    end
    // first step latches the quotient, second takes the remainder from the adder
    if (state_r == amo_pkg::ST_MOD) begin
      if (step_r != 3'd0) begin
        quo_r <= quo_prod[23:16];
      end else begin
        rem_r <= alu_rsp.res[7:0];
      end
      step_r <= step_r - 3'd1;
    end
    if (state_r == amo_pkg::ST_EXEC) begin
      new_word_r <= (rd_data_r & ~(mask << sh)) | ((nv & mask) << sh);
      if (opc_r == amo_pkg::OP_CAS) begin
        wr_en_r <= cas_hit;
        done_r  <= cas_hit;
        res_r   <= old_val;
      end else begin
        wr_en_r <= 1'b1;
        done_r  <= 1'b1;
        case (opc_r) inside
          amo_pkg::OP_RELEASE:                      res_r <= '0;
          [amo_pkg::OP_T_ADD : amo_pkg::OP_T_NAND]: res_r <= nv;
          default:                                  res_r <= old_val;
        endcase
      end
    end
  end

  // Memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == amo_pkg::ST_READ) rd_data_r <= mem[idx];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r  <= res_r;
      out_done_r <= done_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_swap_done    = out_done_r;
  assign out_align_error  = out_err_r;

endmodule

>>> hdl/amo_alu.sv
module amo_alu (
  input  amo_pkg::alu_req_t req,
  output amo_pkg::alu_rsp_t rsp
);

  logic [amo_pkg::DATA_W:0] sum;

  // Single adder serves both add and subtract
  always_comb begin
    if (req.op == amo_pkg::ALU_SUB) begin
      sum = {1'b0, req.a} + {1'b0, ~req.b} + 65'd1;
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  always_comb begin
    rsp.carry = sum[amo_pkg::DATA_W];
    case (req.op)
      amo_pkg::ALU_ADD:  rsp.res = sum[amo_pkg::DATA_W-1:0];
      amo_pkg::ALU_SUB:  rsp.res = sum[amo_pkg::DATA_W-1:0];
      amo_pkg::ALU_AND:  rsp.res = req.a & req.b;
      amo_pkg::ALU_OR:   rsp.res = req.a | req.b;
      amo_pkg::ALU_XOR:  rsp.res = req.a ^ req.b;
      amo_pkg::ALU_NAND: rsp.res = ~(req.a & req.b);
      default:           rsp.res = '0;
    endcase
  end

endmodule

>>> hdl/amo_chk.sv
module amo_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [3:0]  in_opcode,
  input logic [10:0] in_byte_address,
  input logic [1:0]  in_size_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_value,
  input logic        out_swap_done,
  input logic        out_align_error
);

  logic acc;
  logic bad_align;

  assign acc       = in_valid && in_ready;
  assign bad_align = ((in_size_code == amo_pkg::SZ_2) && in_byte_address[0]) ||
                     ((in_size_code == amo_pkg::SZ_4) && (in_byte_address[1:0] != 2'd0)) ||
                     ((in_size_code == amo_pkg::SZ_8) && (in_byte_address[2:0] != 3'd0));

  // Reset leaves no request open and no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid high right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
      $stable(out_swap_done) && $stable(out_align_error))
    else $error("result changed while stalled");

  // One transaction in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready)
    else $error("ready again right after accept");

  // Unused opcode accepted while output is free gives an all-zero result
  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !out_valid && (in_opcode == amo_pkg::OP_NONE) |-> ##2
      out_valid && (out_result_value == 64'd0) && !out_swap_done && !out_align_error)
    else $error("unused opcode result wrong");

  // Misaligned request accepted while output is free is flagged
  a_misaligned: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !out_valid && (in_opcode != amo_pkg::OP_NONE) && bad_align |-> ##2
      out_valid && out_align_error && (out_result_value == 64'd0) && !out_swap_done)
    else $error("misaligned request not flagged");

endmodule

bind atomic_memory_op_unit amo_chk u_amo_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_opcode        (in_opcode),
  .in_byte_address  (in_byte_address),
  .in_size_code     (in_size_code),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_swap_done    (out_swap_done),
  .out_align_error  (out_align_error)
);

>>> verif/atomic_result_checker.sv
// Watches both channels of the atomic unit, keeps a shadow copy of the word
// store, predicts one result per accepted request and compares in order.
module atomic_result_checker #(
  parameter int MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [10:0] in_byte_address,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_operand_value,
  input  logic [63:0] in_compare_value,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_value,
  input  logic        out_swap_done,
  input  logic        out_align_error,

  output int          err_cnt,
  output int          pend_cnt
);

  typedef struct packed {
    logic [63:0] value;
    logic        swap_done;
    logic        align_error;
  } amo_result_t;

  logic [63:0] shadow_words [MEM_WORDS];
  amo_result_t expected_results [$];
  int          fail_tally;

  // lane mask for the access size
  function automatic logic [63:0] width_mask(input logic [1:0] sz);
    logic [63:0] m;
    case (sz)
      amo_pkg::SZ_1: m = 64'hFF;
      amo_pkg::SZ_2: m = 64'hFFFF;
      amo_pkg::SZ_4: m = 64'hFFFF_FFFF;
      default:       m = '1;
    endcase
    return m;
  endfunction

  // one read-modify-write on the shadow store; returns the reported result
  function automatic amo_result_t apply_atomic(input logic [3:0] opc,
                                               input logic [10:0] addr,
                                               input logic [1:0] sz,
                                               input logic [63:0] opv,
                                               input logic [63:0] cmpv);
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] word;
    logic [63:0] old;
    logic [63:0] nv;
    int unsigned idx;
    int unsigned shift;
    logic        wr;
    amo_result_t r;
    m = width_mask(sz);
    b = opv & m;
    c = cmpv & m;
    r = '0;
    if (opc == amo_pkg::OP_NONE) return r;
    if ((addr & ((11'd1 << sz) - 11'd1)) != 11'd0) begin
      r.align_error = 1'b1;
      return r;
    end
    idx   = addr[10:3] % MEM_WORDS;
    shift = addr[2:0] * 8;
    word  = shadow_words[idx];
    old   = (word >> shift) & m;
    wr    = 1'b1;
    nv    = '0;
    r.swap_done = 1'b1;
    r.value     = old;
    case (opc)
      amo_pkg::OP_XCHG:    nv = b;
      amo_pkg::OP_RELEASE: begin
        nv = '0;
        r.value = '0;
      end
      amo_pkg::OP_CAS: begin
        if (old == c) begin
          nv = b;
        end else begin
          wr = 1'b0;
          r.swap_done = 1'b0;
        end
      end
      amo_pkg::OP_F_ADD, amo_pkg::OP_T_ADD: nv = (old + b) & m;
      amo_pkg::OP_F_SUB, amo_pkg::OP_T_SUB: nv = (old - b) & m;
      amo_pkg::OP_F_AND, amo_pkg::OP_T_AND: nv = old & b;
      amo_pkg::OP_F_OR,  amo_pkg::OP_T_OR:  nv = old | b;
      amo_pkg::OP_F_XOR, amo_pkg::OP_T_XOR: nv = old ^ b;
      default:                              nv = (~(old & b)) & m;
    endcase
    // op-then-fetch reports the new lane value
    if (opc >= amo_pkg::OP_T_ADD) r.value = nv;
    if (wr) shadow_words[idx] = (word & ~(m << shift)) | (nv << shift);
    return r;
  endfunction

  // compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    amo_result_t exp_r;
    amo_result_t got_r;
    if (!rst_n) begin
      for (int i = 0; i < MEM_WORDS; i++) shadow_words[i] = '0;
      expected_results.delete();
      fail_tally = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_r = '{out_result_value, out_swap_done, out_align_error};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction value=%h swap_done=%b align_error=%b",
                   $time, got_r.value, got_r.swap_done, got_r.align_error);
          fail_tally++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.value !== exp_r.value) begin
            $display("%0t: result_value expected %h actual %h",
                     $time, exp_r.value, got_r.value);
            fail_tally++;
          end
          if (got_r.swap_done !== exp_r.swap_done) begin
            $display("%0t: swap_done expected %b actual %b",
                     $time, exp_r.swap_done, got_r.swap_done);
            fail_tally++;
          end
          if (got_r.align_error !== exp_r.align_error) begin
            $display("%0t: align_error expected %b actual %b",
                     $time, exp_r.align_error, got_r.align_error);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_atomic(in_opcode, in_byte_address, in_size_code,
                                                in_operand_value, in_compare_value));
      end
    end
    err_cnt  <= fail_tally;
    pend_cnt <= expected_results.size();
  end

endmodule

>>> verif/tb_atomic_memory_op_unit.sv
// Stimulus and verdict for the atomic unit; checking lives in the checker.
module tb_atomic_memory_op_unit;

  localparam int WORDS      = 256;
  localparam int NUM_RANDOM = 550;
  localparam int DRAIN_CYC  = 30;
  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_opcode;
  logic [10:0] in_byte_address;
  logic [1:0]  in_size_code;
  logic [63:0] in_operand_value;
  logic [63:0] in_compare_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_value;
  logic        out_swap_done;
  logic        out_align_error;

  int          err_cnt;
  int          pend_cnt;
  logic        steady;     // no idling on either side while set
  int          ready_hold;
  int          quiet_cyc;

  atomic_memory_op_unit #(.MEM_WORDS(WORDS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_byte_address  (in_byte_address),
    .in_size_code     (in_size_code),
    .in_operand_value (in_operand_value),
    .in_compare_value (in_compare_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_swap_done    (out_swap_done),
    .out_align_error  (out_align_error)
  );

  atomic_result_checker #(.MEM_WORDS(WORDS)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_byte_address  (in_byte_address),
    .in_size_code     (in_size_code),
    .in_operand_value (in_operand_value),
    .in_compare_value (in_compare_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_swap_done    (out_swap_done),
    .out_align_error  (out_align_error),
    .err_cnt          (err_cnt),
    .pend_cnt         (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall after each accepted result
  always @(posedge clk) begin
    int hold_draw;
    if (!rst_n) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      hold_draw  = steady ? 0 : $urandom_range(0, 5);
      ready_hold <= hold_draw;
      out_ready  <= (hold_draw == 0);
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick_data();
    logic [63:0] d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      default: d = {$urandom, $urandom};
    endcase
    return d;
  endfunction

  // mostly aligned, mostly within a few words so operations interact
  function automatic logic [10:0] pick_addr(input logic [1:0] sz);
    logic [7:0] widx;
    logic [2:0] offs;
    widx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    offs = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) >= 15) offs = offs & ~3'((1 << sz) - 1);
    return {widx, offs};
  endfunction

  // present one request after a random gap and hold it until accepted
  task automatic send_req(input logic [3:0] opc, input logic [10:0] addr,
                          input logic [1:0] sz, input logic [63:0] opv,
                          input logic [63:0] cmpv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= opc;
    in_byte_address  <= addr;
    in_size_code     <= sz;
    in_operand_value <= opv;
    in_compare_value <= cmpv;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int          sent;
    int          flip;
    logic [1:0]  sz;
    logic [10:0] addr;
    logic [63:0] v;
    rst_n            = 1'b0;
    steady           = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = amo_pkg::OP_XCHG;
    in_byte_address  = '0;
    in_size_code     = amo_pkg::SZ_1;
    in_operand_value = '0;
    in_compare_value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap at full width, every operation, CAS both ways
    send_req(amo_pkg::OP_XCHG,    11'd0,    amo_pkg::SZ_8, '1, '0);
    send_req(amo_pkg::OP_F_ADD,   11'd0,    amo_pkg::SZ_8, 64'd1, '0);
    send_req(amo_pkg::OP_T_SUB,   11'd0,    amo_pkg::SZ_8, 64'd1, '0);
    send_req(amo_pkg::OP_CAS,     11'd0,    amo_pkg::SZ_8, 64'h0123_4567_89AB_CDEF, '1);
    send_req(amo_pkg::OP_CAS,     11'd0,    amo_pkg::SZ_8, '1, '0);
    send_req(amo_pkg::OP_F_AND,   11'd0,    amo_pkg::SZ_4, 64'hFFFF_0000_F0F0_F0F0, '0);
    send_req(amo_pkg::OP_F_OR,    11'd4,    amo_pkg::SZ_4, '1, '0);
    send_req(amo_pkg::OP_F_XOR,   11'd2,    amo_pkg::SZ_2, 64'hAAAA_5555_A5A5_5A5A, '0);
    send_req(amo_pkg::OP_F_NAND,  11'd1,    amo_pkg::SZ_1, 64'hFF, '0);
    send_req(amo_pkg::OP_F_SUB,   11'd8,    amo_pkg::SZ_1, 64'd1, '0);
    send_req(amo_pkg::OP_T_ADD,   11'd2046, amo_pkg::SZ_2, '1, '0);
    send_req(amo_pkg::OP_T_AND,   11'd2040, amo_pkg::SZ_8, 64'h8000_0000_0000_0001, '0);
    send_req(amo_pkg::OP_T_OR,    11'd2044, amo_pkg::SZ_4, 64'h1234_5678_8000_0001, '0);
    send_req(amo_pkg::OP_T_XOR,   11'd2047, amo_pkg::SZ_1, '1, '0);
    send_req(amo_pkg::OP_T_NAND,  11'd2040, amo_pkg::SZ_8, '1, '0);
    send_req(amo_pkg::OP_XCHG,    11'd16,   amo_pkg::SZ_2, 64'hFFFF_FFFF_FFFF_BEEF, '0);
    send_req(amo_pkg::OP_CAS,     11'd16,   amo_pkg::SZ_2, 64'h1111, 64'h5A5A_0000_0000_BEEF);
    send_req(amo_pkg::OP_RELEASE, 11'd0,    amo_pkg::SZ_8, '1, '1);
    // misaligned for each size above one byte, and the unused opcode
    send_req(amo_pkg::OP_XCHG,    11'd1,    amo_pkg::SZ_2, '1, '0);
    send_req(amo_pkg::OP_XCHG,    11'd2,    amo_pkg::SZ_4, '1, '0);
    send_req(amo_pkg::OP_F_ADD,   11'd4,    amo_pkg::SZ_8, '1, '0);
    send_req(amo_pkg::OP_CAS,     11'd2047, amo_pkg::SZ_8, '1, '0);
    send_req(amo_pkg::OP_NONE,    11'd3,    amo_pkg::SZ_8, '1, '1);
    send_req(amo_pkg::OP_NONE,    11'd0,    amo_pkg::SZ_1, '1, '1);
    send_req(amo_pkg::OP_XCHG,    11'd1,    amo_pkg::SZ_8, '0, '0);

    // random: single ops, plus exchange/CAS pairs that mostly hit the compare
    sent = 0;
    while (sent < NUM_RANDOM) begin
      if (sent % 100 < 2) steady <= ($urandom_range(0, 2) == 0);
      sz   = 2'($urandom_range(0, 3));
      addr = pick_addr(sz);
      if ($urandom_range(0, 99) < 25) begin
        v = pick_data();
        send_req(amo_pkg::OP_XCHG, addr, sz, v, pick_data());
        if ($urandom_range(0, 3) == 0) begin
          flip    = $urandom_range(0, 7);
          v[flip] = ~v[flip];
        end
        send_req(amo_pkg::OP_CAS, addr, sz, pick_data(), v);
        sent += 2;
      end else begin
        send_req(4'($urandom_range(0, 15)), addr, sz, pick_data(), pick_data());
        sent += 1;
      end
    end
    in_valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/amo_pkg.sv
hdl/amo_alu.sv
hdl/atomic_memory_op_unit.sv
hdl/amo_chk.sv
verif/atomic_result_checker.sv
verif/tb_atomic_memory_op_unit.sv
